// ===== rtl/fdes_pkg.sv =====
package fdes_pkg;

   // Field widths fixed by the entry and result formats.
   localparam int NAME_BASE_W = 64;
   localparam int NAME_EXT_W  = 24;
   localparam int ATTR_W      = 8;
   localparam int CLUSTER_W   = 32;
   localparam int SIZE_W      = 32;
   localparam int LIMIT_W     = 31;
   localparam int IDX_W       = 12;

   // Default directory depth handed to the top level.
   localparam int FDES_MAX_ENTRIES = 4096;

   // Register file: 64-bit data, registers on 8-byte boundaries.
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;

   typedef enum logic [1:0] {
      CSR_TARGET_BASE = 2'd0,
      CSR_TARGET_EXT  = 2'd1,
      CSR_SIZE_LIMIT  = 2'd2,
      CSR_UNUSED      = 2'd3
   } fdes_csr_type;

   localparam logic [NAME_BASE_W-1:0] TARGET_BASE_RESET = 64'h2020_2020_2020_2020;
   localparam logic [NAME_EXT_W-1:0]  TARGET_EXT_RESET  = 24'h20_2020;
   localparam logic [LIMIT_W-1:0]     SIZE_LIMIT_RESET  = '0;

   // Special first name bytes and attribute masks.
   localparam logic [7:0] BYTE_END      = 8'h00;
   localparam logic [7:0] BYTE_DELETED  = 8'hE5;
   localparam logic [3:0] ATTR_LFN      = 4'hF;
   localparam int         ATTR_DIR_BIT  = 4;
   localparam logic [CLUSTER_W-1:0] FIRST_DATA_CLUSTER = 32'd2;

   typedef enum logic [2:0] {
      CLS_LFN     = 3'd0,
      CLS_DELETED = 3'd1,
      CLS_END     = 3'd2,
      CLS_MATCH   = 3'd3,
      CLS_MISS    = 3'd4,
      CLS_IGNORED = 3'd5
   } fdes_class_type;

   // One directory entry as it arrives.
   typedef struct packed {
      logic [NAME_BASE_W-1:0] name_base;
      logic [NAME_EXT_W-1:0]  name_ext;
      logic [ATTR_W-1:0]      attributes;
      logic [CLUSTER_W-1:0]   entry_cluster;
      logic [SIZE_W-1:0]      entry_size;
      logic                   last_entry;
   } fdes_entry_type;

   // One classified entry as it leaves.
   typedef struct packed {
      fdes_class_type         entry_class;
      logic [IDX_W-1:0]       entry_index;
      logic                   is_directory;
      logic [CLUSTER_W-1:0]   found_cluster;
      logic [SIZE_W-1:0]      clipped_size;
      logic                   bad_cluster;
      logic                   scan_found;
      logic                   free_valid;
      logic [IDX_W-1:0]       free_index;
      logic                   scan_done;
   } fdes_result_type;

   // Search target as held in the register file.
   typedef struct packed {
      logic [NAME_BASE_W-1:0] target_base;
      logic [NAME_EXT_W-1:0]  target_ext;
      logic [LIMIT_W-1:0]     size_limit;
   } fdes_cfg_type;

endpackage

// ===== rtl/fdes_if.sv =====
// Entry channel into the scanner.
interface fdes_req_if;
   import fdes_pkg::*;

   logic           valid;
   logic           ready;
   fdes_entry_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// Result channel out of the scanner.
interface fdes_rsp_if;
   import fdes_pkg::*;

   logic            valid;
   logic            ready;
   fdes_result_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/fdes_scan.sv =====
module fdes_scan #(
   parameter int MAX_ENTRIES = fdes_pkg::FDES_MAX_ENTRIES
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  fdes_pkg::fdes_entry_type entry,
   input  fdes_pkg::fdes_cfg_type   cfg,
   output fdes_pkg::fdes_result_type result
);
   import fdes_pkg::*;

   // The position counter must be able to hold MAX_ENTRIES itself.
   localparam int POS_W  = $clog2(MAX_ENTRIES + 1);
   localparam int WIDE_W = (POS_W > IDX_W) ? POS_W : IDX_W;
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_ENTRIES);
   localparam logic [POS_W-1:0] POS_TOP   = POS_W'(MAX_ENTRIES - 1);

   logic [POS_W-1:0] position_ff, position_in;
   logic             ended_ff, ended_in;
   logic             matched_ff, matched_in;
   logic             have_free_ff, have_free_in;
   logic [IDX_W-1:0] first_free_ff, first_free_in;

   logic [7:0]        first_byte;
   logic              at_limit;
   logic [POS_W-1:0]  pos_clamped;
   logic [WIDE_W-1:0] pos_wide;
   logic [IDX_W-1:0]  idx;
   logic              name_hit;
   logic [SIZE_W-1:0] limit_wide;
   fdes_class_type    cls;

   // Classify the entry against the scan state and the target name.
   always_comb begin
      first_byte  = entry.name_base[NAME_BASE_W-1 -: 8];
      at_limit    = (position_ff >= POS_LIMIT);
      pos_clamped = (position_ff > POS_TOP) ? POS_TOP : position_ff;
      pos_wide    = WIDE_W'(pos_clamped);
      idx         = pos_wide[IDX_W-1:0];
      name_hit    = (entry.name_base == cfg.target_base) &&
                    (entry.name_ext == cfg.target_ext);
      limit_wide  = {1'b0, cfg.size_limit};

      if (ended_ff || matched_ff || at_limit) begin
         cls = CLS_IGNORED;
      end else if (first_byte == BYTE_END) begin
         cls = CLS_END;
      end else if (first_byte == BYTE_DELETED) begin
         cls = CLS_DELETED;
      end else if (entry.attributes[3:0] == ATTR_LFN) begin
         cls = CLS_LFN;
      end else if (name_hit) begin
         cls = CLS_MATCH;
      end else begin
         cls = CLS_MISS;
      end
   end

   // State after this entry, before any end-of-scan clear.
   always_comb begin
      ended_in      = ended_ff | (cls == CLS_END);
      matched_in    = matched_ff | (cls == CLS_MATCH);
      have_free_in  = have_free_ff;
      first_free_in = first_free_ff;
      if ((cls == CLS_END || cls == CLS_DELETED) && !have_free_ff) begin
         have_free_in  = 1'b1;
         first_free_in = idx;
      end
      position_in = at_limit ? position_ff : position_ff + POS_W'(1);
   end

   // Result word; match details and the scan summary are zero elsewhere.
   always_comb begin
      result              = '0;
      result.entry_class  = cls;
      result.entry_index  = idx;
      if (cls == CLS_MATCH) begin
         result.is_directory  = entry.attributes[ATTR_DIR_BIT];
         result.found_cluster = entry.entry_cluster;
         result.clipped_size  = (entry.entry_size > limit_wide) ? limit_wide
                                                                : entry.entry_size;
         result.bad_cluster   = (entry.entry_cluster < FIRST_DATA_CLUSTER);
      end
      if (entry.last_entry) begin
         result.scan_found = matched_in;
         result.free_valid = have_free_in;
         result.free_index = have_free_in ? first_free_in : '0;
         result.scan_done  = 1'b1;
      end
   end

   // Scan state advances once per entry and clears after the last one.
   always_ff @(posedge clock) begin
      if (reset || (step && entry.last_entry)) begin
         position_ff   <= '0;
         ended_ff      <= 1'b0;
         matched_ff    <= 1'b0;
         have_free_ff  <= 1'b0;
         first_free_ff <= '0;
      end else if (step) begin
         position_ff   <= position_in;
         ended_ff      <= ended_in;
         matched_ff    <= matched_in;
         have_free_ff  <= have_free_in;
         first_free_ff <= first_free_in;
      end
   end

endmodule

// ===== rtl/fat_directory_entry_scanner_top.sv =====
// Channel   Direction  Handshake      Word
// req_chan  in         valid/ready    one directory entry (fdes_entry_type)
// rsp_chan  out        valid/ready    one classified entry (fdes_result_type)
// APB       in/out     psel/penable   target_base @0x00, target_ext @0x08, size_limit @0x10
//
// One entry per cycle sustained while the result side is ready. The result word is
// registered: an accepted entry goes into the entry register, then is classified and
// compared into the result register.
// The 88-bit name compare and the size clip sit in the single classify stage.
// Reset is synchronous; it clears the scan state and both valid flags and sets the registers to their reset values.
// A stalled result holds; one more entry is taken into the entry register meanwhile.
module fat_directory_entry_scanner_top #(
   parameter int MAX_ENTRIES = fdes_pkg::FDES_MAX_ENTRIES
) (
   input  logic                              clock,
   input  logic                              reset,
   fdes_req_if.sink                          req_chan,
   fdes_rsp_if.source                        rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fdes_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [fdes_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [fdes_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import fdes_pkg::*;

   fdes_cfg_type    cfg_ff;
   fdes_csr_type    csr_sel;
   logic            csr_write;

   logic            in_valid_ff, in_valid_in;
   fdes_entry_type  in_data_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   fdes_result_type rsp_data_ff;
   fdes_result_type scan_result;
   logic            req_take;
   logic            advance;

   // Register file decode; writes complete in the access cycle.
   assign pready    = 1'b1;
   assign csr_sel   = fdes_csr_type'(paddr[CSR_ADDR_W-1:3]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_base <= TARGET_BASE_RESET;
         cfg_ff.target_ext  <= TARGET_EXT_RESET;
         cfg_ff.size_limit  <= SIZE_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_sel)
            CSR_TARGET_BASE: cfg_ff.target_base <= pwdata[NAME_BASE_W-1:0];
            CSR_TARGET_EXT:  cfg_ff.target_ext  <= pwdata[NAME_EXT_W-1:0];
            CSR_SIZE_LIMIT:  cfg_ff.size_limit  <= pwdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         CSR_TARGET_BASE: prdata = cfg_ff.target_base;
         CSR_TARGET_EXT:  prdata = CSR_DATA_W'(cfg_ff.target_ext);
         CSR_SIZE_LIMIT:  prdata = CSR_DATA_W'(cfg_ff.size_limit);
         default:         prdata = '0;
      endcase
   end

   // Two-stage flow: the entry register advances when the result register frees up.
   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign in_valid_in    = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in   = advance || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_chan.data;
      end
      if (advance) begin
         rsp_data_ff <= scan_result;
      end
   end

   // Classification and scan bookkeeping.
   fdes_scan #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .entry  (in_data_ff),
      .cfg    (cfg_ff),
      .result (scan_result)
   );

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

`ifndef SYNTHESIS
   // Summary fields only appear on the word that closes a scan.
   a_summary_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.scan_done |->
         !rsp_data_ff.scan_found && !rsp_data_ff.free_valid &&
         rsp_data_ff.free_index == '0)
      else $error("scan summary set on a word that does not end the scan");

   // Match details stay zero unless the entry matched.
   a_details_only_on_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.entry_class != CLS_MATCH |->
         !rsp_data_ff.is_directory && !rsp_data_ff.bad_cluster &&
         rsp_data_ff.found_cluster == '0 && rsp_data_ff.clipped_size == '0)
      else $error("match details on a word that did not match");

   // The reported size never exceeds the configured limit.
   a_size_clipped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.clipped_size <= {1'b0, cfg_ff.size_limit})
      else $error("clipped size above size_limit");

   // A result cannot be overwritten while it is stalled.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !advance)
      else $error("result register loaded while stalled");
`endif

endmodule

// ===== verif/fdes_scan_checker.sv =====
`timescale 1ns / 1ps

// Watches the entry, result and register ports of the directory scanner.
// It keeps its own scan state, works out the classification of each accepted
// entry and compares each accepted result word with the oldest one waiting.
module fdes_scan_checker #(
   parameter int MAX_ENTRIES = fdes_pkg::FDES_MAX_ENTRIES
) (
   input  logic                            clock,
   input  logic                            reset,
   fdes_req_if                             req_mon,
   fdes_rsp_if                             rsp_mon,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [fdes_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [fdes_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic [fdes_pkg::CSR_DATA_W-1:0] prdata,
   input  logic                            pready,
   output int                              fail_count,
   output int                              pending
);
   import fdes_pkg::*;

   // Search target as last written.
   logic [NAME_BASE_W-1:0] want_base;
   logic [NAME_EXT_W-1:0]  want_ext;
   logic [LIMIT_W-1:0]     clip_limit;

   // Scan state.
   int unsigned            scan_pos;
   bit                     scan_ended;
   bit                     scan_matched;
   bit                     free_seen;
   logic [IDX_W-1:0]       free_slot;

   fdes_result_type        expected_q[$];
   int                     errors = 0;

   function automatic void clear_scan();
      scan_pos = 0;
      scan_ended = 1'b0;
      scan_matched = 1'b0;
      free_seen = 1'b0;
      free_slot = '0;
   endfunction

   // Classify one entry and advance the scan state.
   function automatic fdes_result_type classify_entry(input fdes_entry_type e);
      fdes_result_type r;
      logic [7:0]      lead;
      r = '0;
      lead = e.name_base[NAME_BASE_W-1 -: 8];
      r.entry_index = IDX_W'(scan_pos > MAX_ENTRIES - 1 ? MAX_ENTRIES - 1 : scan_pos);

      // Deletion is tested before the long-name attribute pattern.
      if (scan_ended || scan_matched || scan_pos >= MAX_ENTRIES) begin
         r.entry_class = CLS_IGNORED;
      end else if (lead == BYTE_END) begin
         r.entry_class = CLS_END;
         scan_ended = 1'b1;
      end else if (lead == BYTE_DELETED) begin
         r.entry_class = CLS_DELETED;
      end else if (e.attributes[3:0] == ATTR_LFN) begin
         r.entry_class = CLS_LFN;
      end else if (e.name_base == want_base && e.name_ext == want_ext) begin
         r.entry_class = CLS_MATCH;
         scan_matched = 1'b1;
         r.is_directory = e.attributes[ATTR_DIR_BIT];
         r.found_cluster = e.entry_cluster;
         r.clipped_size = (e.entry_size > SIZE_W'(clip_limit)) ? SIZE_W'(clip_limit)
                                                               : e.entry_size;
         r.bad_cluster = (e.entry_cluster < FIRST_DATA_CLUSTER);
      end else begin
         r.entry_class = CLS_MISS;
      end

      // The first free or end slot of the scan is remembered.
      if ((r.entry_class == CLS_END || r.entry_class == CLS_DELETED) && !free_seen) begin
         free_seen = 1'b1;
         free_slot = r.entry_index;
      end
      if (scan_pos < MAX_ENTRIES)
         scan_pos++;

      // The last entry carries the summary, which includes the entry itself.
      if (e.last_entry) begin
         r.scan_found = scan_matched;
         r.free_valid = free_seen;
         r.free_index = free_seen ? free_slot : '0;
         r.scan_done = 1'b1;
         clear_scan();
      end
      return r;
   endfunction

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t %s: expected %0h, actual %0h", $time, label, want, got);
      end
   endtask

   task automatic compare_result(input fdes_result_type want, input fdes_result_type got);
      check_field("entry_class", want.entry_class, got.entry_class);
      check_field("entry_index", want.entry_index, got.entry_index);
      check_field("is_directory", want.is_directory, got.is_directory);
      check_field("found_cluster", want.found_cluster, got.found_cluster);
      check_field("clipped_size", want.clipped_size, got.clipped_size);
      check_field("bad_cluster", want.bad_cluster, got.bad_cluster);
      check_field("scan_found", want.scan_found, got.scan_found);
      check_field("free_valid", want.free_valid, got.free_valid);
      check_field("free_index", want.free_index, got.free_index);
      check_field("scan_done", want.scan_done, got.scan_done);
   endtask

   // Register writes update the target; reads must return the held value.
   task automatic watch_csr();
      fdes_csr_type        sel;
      logic [CSR_DATA_W-1:0] held;
      sel = fdes_csr_type'(paddr[4:3]);
      if (paddr[2:0] == 3'b000) begin
         if (pwrite) begin
            case (sel)
               CSR_TARGET_BASE: want_base = pwdata[NAME_BASE_W-1:0];
               CSR_TARGET_EXT:  want_ext = pwdata[NAME_EXT_W-1:0];
               CSR_SIZE_LIMIT:  clip_limit = pwdata[LIMIT_W-1:0];
               default: ;
            endcase
         end else if (sel != CSR_UNUSED) begin
            case (sel)
               CSR_TARGET_BASE: held = CSR_DATA_W'(want_base);
               CSR_TARGET_EXT:  held = CSR_DATA_W'(want_ext);
               default:         held = CSR_DATA_W'(clip_limit);
            endcase
            if (prdata !== held) begin
               errors++;
               $display("%0t register %s read: expected %0h, actual %0h",
                        $time, sel.name(), held, prdata);
            end
         end
      end
   endtask

   // Results are taken before entries: a word accepted at this edge cannot
   // belong to an entry accepted at the same edge.
   always @(posedge clock) begin : watch
      fdes_result_type head;
      if (reset) begin
         want_base = TARGET_BASE_RESET;
         want_ext = TARGET_EXT_RESET;
         clip_limit = SIZE_LIMIT_RESET;
         clear_scan();
         expected_q.delete();
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (expected_q.size() == 0) begin
               errors++;
               $display("%0t result word: expected none, actual %h", $time, rsp_mon.data);
            end else begin
               head = expected_q.pop_front();
               compare_result(head, rsp_mon.data);
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            expected_q.push_back(classify_entry(req_mon.data));
         if (psel === 1'b1 && penable === 1'b1 && pready === 1'b1)
            watch_csr();
      end
      fail_count <= errors;
      pending <= expected_q.size();
   end

endmodule

// ===== verif/fat_directory_entry_scanner_top_tb.sv =====
`timescale 1ns / 1ps

module fat_directory_entry_scanner_top_tb;
   import fdes_pkg::*;

   localparam int SCAN_DEPTH   = FDES_MAX_ENTRIES;
   localparam int RANDOM_ITEMS = 1200;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_LIMIT  = 2000;

   localparam logic [NAME_BASE_W-1:0] README_NAME = 64'h5245_4144_4D45_2020;
   localparam logic [NAME_EXT_W-1:0]  TXT_EXT     = 24'h54_5854;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int                    fail_count;
   int                    pending;
   int                    cycle_count = 0;
   int                    live_items = 0;
   bit                    idle_on = 1'b1;

   // Target as last written, used to steer the entries toward it.
   logic [NAME_BASE_W-1:0] cur_base;
   logic [NAME_EXT_W-1:0]  cur_ext;
   logic [LIMIT_W-1:0]     cur_limit;

   fdes_req_if req_if();
   fdes_rsp_if rsp_if();

   fat_directory_entry_scanner_top #(
      .MAX_ENTRIES(SCAN_DEPTH)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   fdes_scan_checker #(
      .MAX_ENTRIES(SCAN_DEPTH)
   ) u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_mon   (req_if),
      .rsp_mon   (rsp_if),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .fail_count(fail_count),
      .pending   (pending)
   );

   // 20 ns clock.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Gap before the next word on either side; some phases run with none.
   function automatic int draw_wait();
      if (!idle_on)
         return 0;
      if ($urandom_range(0, 2) == 0)
         return $urandom_range(0, 17);
      return 0;
   endfunction

   // Result side: ready may drop for a random stretch before a word.
   initial begin : result_sink
      int stall;
      rsp_if.ready = 1'b0;
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do
            @(posedge clock);
         while (!(rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1));
      end
   end

   function automatic fdes_entry_type mk_entry(input logic [NAME_BASE_W-1:0] base,
                                               input logic [NAME_EXT_W-1:0] ext,
                                               input logic [ATTR_W-1:0] attr,
                                               input logic [CLUSTER_W-1:0] clus,
                                               input logic [SIZE_W-1:0] size,
                                               input logic last);
      fdes_entry_type e;
      e.name_base = base;
      e.name_ext = ext;
      e.attributes = attr;
      e.entry_cluster = clus;
      e.entry_size = size;
      e.last_entry = last;
      return e;
   endfunction

   // Present one word and hold it until it is taken. Valid stays high when
   // the next word follows without a gap.
   task automatic send_entry(input fdes_entry_type e);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data <= e;
      do
         @(posedge clock);
      while (!(req_if.valid === 1'b1 && req_if.ready === 1'b1));
   endtask

   // One register access: setup phase, access phase, then a return to idle.
   task automatic csr_access(input bit is_write, input fdes_csr_type sel,
                             input logic [CSR_DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= is_write;
      paddr <= CSR_ADDR_W'({sel, 3'b000});
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do
         @(posedge clock);
      while (pready !== 1'b1);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_back();
      csr_access(1'b0, CSR_TARGET_BASE, '0);
      csr_access(1'b0, CSR_TARGET_EXT, '0);
      csr_access(1'b0, CSR_SIZE_LIMIT, '0);
   endtask

   task automatic load_target(input logic [63:0] base, input logic [63:0] ext,
                              input logic [63:0] limit);
      csr_access(1'b1, CSR_TARGET_BASE, base);
      csr_access(1'b1, CSR_TARGET_EXT, ext);
      csr_access(1'b1, CSR_SIZE_LIMIT, limit);
      read_back();
      cur_base = base;
      cur_ext = ext[NAME_EXT_W-1:0];
      cur_limit = limit[LIMIT_W-1:0];
   endtask

   // Wait until every result is out and the pipeline is empty.
   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // A random entry, leaning toward the searched name and the special bytes.
   function automatic fdes_entry_type pick_entry();
      fdes_entry_type e;
      int             kind;
      int             flip;
      e = mk_entry({$urandom, $urandom}, NAME_EXT_W'($urandom), ATTR_W'($urandom),
                   $urandom, $urandom, 1'b0);
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
         e.name_base = cur_base;
         e.name_ext = cur_ext;
         if ($urandom_range(0, 3) == 0)
            e.entry_cluster = $urandom_range(0, 3);
         if ($urandom_range(0, 1) == 1)
            e.entry_size = SIZE_W'(cur_limit) + SIZE_W'($urandom_range(0, 2)) - 32'd1;
      end else if (kind < 35) begin
         flip = $urandom_range(0, NAME_BASE_W + NAME_EXT_W - 1);
         {e.name_base, e.name_ext} = {cur_base, cur_ext} ^ (88'd1 << flip);
      end else if (kind < 50) begin
         e.name_base[63:56] = BYTE_DELETED;
         if ($urandom_range(0, 3) == 0)
            e.attributes[3:0] = ATTR_LFN;
      end else if (kind < 58) begin
         e.name_base[63:56] = BYTE_END;
      end else if (kind < 70) begin
         e.attributes[3:0] = ATTR_LFN;
      end
      return e;
   endfunction

   // One directory scan. Once a match or an end marker closes it, a few
   // ignored entries may follow before the last one.
   task automatic run_scan(input int len);
      fdes_entry_type e;
      bit             closed;
      bit             closes;
      int             tail;
      int             spent;
      closed = 1'b0;
      spent = 0;
      tail = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) begin
         e = pick_entry();
         closes = (e.name_base[63:56] == BYTE_END) ||
                  ({e.name_base, e.name_ext} == {cur_base, cur_ext} &&
                   e.name_base[63:56] != BYTE_DELETED && e.attributes[3:0] != ATTR_LFN);
         if (closed)
            spent++;
         e.last_entry = (i == len - 1) || (closed && spent > tail) ||
                        (!closed && closes && $urandom_range(0, 2) == 0);
         send_entry(e);
         live_items++;
         closed |= closes;
         if (e.last_entry)
            break;
      end
   endtask

   task automatic new_target();
      logic [63:0] base;
      logic [63:0] ext;
      logic [63:0] limit;
      base = {$urandom, $urandom};
      ext = {$urandom, $urandom};
      limit = {$urandom, $urandom};
      case ($urandom_range(0, 4))
         0: base[63:56] = 8'h41 + 8'($urandom_range(0, 25));
         1: ;
         2: base = '1;
         3: base = TARGET_BASE_RESET;
         default: base[63:56] = $urandom_range(0, 1) ? BYTE_END : BYTE_DELETED;
      endcase
      case ($urandom_range(0, 3))
         0: ;
         1: ext = '0;
         2: ext = 64'hFF_FFFF;
         default: ext = 64'($urandom_range(0, 24'hFF_FFFF));
      endcase
      case ($urandom_range(0, 4))
         0: limit = '0;
         1: limit = 64'h7FFF_FFFF;
         2: limit = 64'($urandom_range(0, 1023));
         3: ;
         default: limit = 64'($urandom);
      endcase
      if ($urandom_range(0, 3) == 0)
         csr_access(1'b1, CSR_UNUSED, {$urandom, $urandom});
      load_target(base, ext, limit);
   endtask

   initial begin : stimulus
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_if.valid = 1'b0;
      req_if.data = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers come out of reset with a blank name and a zero limit.
      read_back();
      load_target(README_NAME, 64'(TXT_EXT), 64'd1000);

      // Long-name, deleted long-name, near miss, deleted, then a match on
      // cluster 0 that is too large; the entry after it is ignored.
      send_entry(mk_entry(64'h4142_4344_4546_4748, TXT_EXT, 8'h0F, 32'd5, 32'd10, 1'b0));
      send_entry(mk_entry({BYTE_DELETED, 56'h42_4344_4546_4748}, TXT_EXT, 8'h0F,
                          32'd0, 32'd0, 1'b0));
      send_entry(mk_entry(README_NAME, 24'h54_5853, 8'h20, 32'd9, 32'd100, 1'b0));
      send_entry(mk_entry({BYTE_DELETED, README_NAME[55:0]}, TXT_EXT, 8'h20,
                          32'd3, 32'd4, 1'b0));
      send_entry(mk_entry(README_NAME, TXT_EXT, 8'h10, 32'd0, 32'd5000, 1'b0));
      send_entry(mk_entry(README_NAME, TXT_EXT, 8'h00, 32'd7, 32'd1, 1'b1));

      // Matching name under long-name attributes, then the end marker; the
      // match after the end marker is ignored.
      send_entry(mk_entry(README_NAME, TXT_EXT, 8'h2F, 32'd4, 32'd8, 1'b0));
      send_entry(mk_entry('0, '0, 8'h00, '0, '0, 1'b0));
      send_entry(mk_entry(README_NAME, TXT_EXT, 8'h20, 32'd4, 32'd8, 1'b0));
      send_entry(mk_entry('1, '0, 8'hFF, '1, '1, 1'b1));

      // Single-entry scans: match on cluster 1, plain miss, end marker.
      send_entry(mk_entry(README_NAME, TXT_EXT, 8'h20, 32'd1, 32'd999, 1'b1));
      send_entry(mk_entry('1, '1, 8'hF0, '1, '1, 1'b1));
      send_entry(mk_entry('0, '1, 8'hFF, '1, '1, 1'b1));
      settle();

      // Unused register, then all-ones target and the widest limit.
      csr_access(1'b1, CSR_UNUSED, '1);
      load_target('1, '1, '1);
      send_entry(mk_entry('1, '1, 8'hF0, '1, '1, 1'b1));
      settle();

      // Zero limit clips every size to nothing.
      load_target('1, '1, '0);
      send_entry(mk_entry({BYTE_DELETED, 56'h0}, '0, 8'h00, '0, '0, 1'b0));
      send_entry(mk_entry('1, '1, 8'h00, 32'd2, 32'd5, 1'b1));

      // Random scans in phases, each with its own target and idling.
      live_items = 0;
      while (live_items < RANDOM_ITEMS) begin
         settle();
         new_target();
         idle_on = ($urandom_range(0, 3) != 0);
         repeat (25) begin
            run_scan($urandom_range(0, 9) == 0 ? $urandom_range(11, 48)
                                               : $urandom_range(1, 10));
         end
      end

      // Drain and give the verdict.
      req_if.valid <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < DRAIN_LIMIT && pending != 0; i++)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (pending != 0)
         $display("%0t %0d results never arrived", $time, pending);
      if (fail_count == 0 && pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
